FILE: sv/autotile_quarter_selector_assert.svh
// Assertion macros for the autotile quarter selector.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef AUTOTILE_QUARTER_SELECTOR_ASSERT_SVH
`define AUTOTILE_QUARTER_SELECTOR_ASSERT_SVH

// same-cycle implication, off during reset
`define AQS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define AQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/aqs_pkg.sv
// Shared constants, register indexes and types of the autotile quarter selector.
// No dependencies.
`default_nettype none

package aqs_pkg;

  localparam int MAP_DIM   = 64;
  localparam int COORD_W   = $clog2(MAP_DIM);
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int TILE_W    = 32;
  localparam int TILE_H    = 32;
  localparam int TILE_BITS = 16;
  localparam int HALF_W    = TILE_W / 2;
  localparam int HALF_H    = TILE_H / 2;

  localparam int NBR_STEPS = 9;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_FULL   = 2'd1;
  localparam logic [1:0] MODE_HORIZ  = 2'd2;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_COLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ROWS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd7;

  // neighbour match bits
  localparam int NB_L  = 0;
  localparam int NB_U  = 1;
  localparam int NB_R  = 2;
  localparam int NB_D  = 3;
  localparam int NB_UL = 4;
  localparam int NB_UR = 5;
  localparam int NB_DL = 6;
  localparam int NB_DR = 7;

  typedef struct packed {
    logic [1:0]  tile_mode;
    logic [14:0] origin_x;
    logic [14:0] origin_y;
    logic [4:0]  count_cols;
    logic [4:0]  count_rows;
    logic [6:0]  map_width;
    logic [6:0]  map_height;
    logic [7:0]  frame_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         eq;
    logic [4:0]         rcnt;
    logic [4:0]         ccnt;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } seq_res_t;

endpackage

`default_nettype wire

FILE: sv/aqs_map_ram.sv
// Single-port tile map memory with registered read data.
// Depends on aqs_pkg.
`default_nettype none

module aqs_map_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [aqs_pkg::ADDR_W-1:0]    addr,
  input  logic [aqs_pkg::TILE_BITS-1:0] wdata,
  output logic [aqs_pkg::TILE_BITS-1:0] rdata
);
  import aqs_pkg::*;

  logic [TILE_BITS-1:0] mem [MAP_DIM*MAP_DIM];
  logic [TILE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/aqs_seq.sv
// Resolve sequencer: walks the cells of a resolve through the map memory,
// one read a cycle, and gathers match flags and block counts. Depends on aqs_pkg, aqs_map_ram.
`default_nettype none
`include "autotile_quarter_selector_assert.svh"

module aqs_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      in_kind,
  input  logic [5:0]                in_col,
  input  logic [5:0]                in_row,
  input  logic [15:0]               in_tile_value,
  input  aqs_pkg::cfg_t             cfg,
  output logic                      busy,
  output logic                      done,
  output aqs_pkg::seq_res_t         res
);
  import aqs_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [1:0] PK_CENTER = 2'd0;
  localparam logic [1:0] PK_NBR    = 2'd1;
  localparam logic [1:0] PK_ROW    = 2'd2;
  localparam logic [1:0] PK_COL    = 2'd3;

  localparam logic [6:0] D_MINUS = 7'h7F;
  localparam logic [6:0] D_PLUS  = 7'h01;

  logic                 state_r, state_nxt;
  logic [3:0]           step_r;
  logic [4:0]           i_r, j_r;
  logic [COORD_W-1:0]   col_r, row_r;
  logic                 pend_v_r;
  logic [1:0]           pend_kind_r;
  logic [4:0]           pend_idx_r;
  logic                 pend_oob_r;
  logic [TILE_BITS-1:0] center_r;
  logic [7:0]           eq_r;
  logic [4:0]           rcnt_r, ccnt_r;
  logic [COORD_W-1:0]   sx_r, sy_r;
  logic                 done_r;

  logic                 iss_v;
  logic [1:0]           iss_kind;
  logic [4:0]           iss_idx;
  logic [6:0]           dc, dr, ncol, nrow;
  logic                 oob;
  logic                 is_single, row_ok, col_ok, accept_res, ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [TILE_BITS-1:0] rd_data, val;
  logic                 hit;

  aqs_map_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tile_value[TILE_BITS-1:0]),
    .rdata (rd_data)
  );

  assign is_single  = !(cfg.tile_mode == MODE_FULL || cfg.tile_mode == MODE_HORIZ);
  assign row_ok     = (i_r < cfg.count_rows) && ({1'b0, i_r} <= row_r);
  assign col_ok     = (j_r < cfg.count_cols) && ({1'b0, j_r} <= col_r);
  assign accept_res = start && (state_r == ST_IDLE) && (in_kind == KIND_RESOLVE);
  assign ram_we     = start && (state_r == ST_IDLE) && (in_kind == KIND_WRITE);

  always_comb begin
    iss_v    = 1'b0;
    iss_kind = PK_CENTER;
    iss_idx  = '0;
    dc       = '0;
    dr       = '0;
    if (state_r == ST_RUN) begin
      if (step_r == 4'd0) begin
        iss_v = 1'b1;
      end else if (!is_single) begin
        if (step_r < 4'(NBR_STEPS)) begin
          iss_v    = 1'b1;
          iss_kind = PK_NBR;
          iss_idx  = 5'(step_r - 4'd1);
          case (step_r)
            4'(NB_L + 1):  dc = D_MINUS;
            4'(NB_U + 1):  dr = D_MINUS;
            4'(NB_R + 1):  dc = D_PLUS;
            4'(NB_D + 1):  dr = D_PLUS;
            4'(NB_UL + 1): begin
              dc = D_MINUS;
              dr = D_MINUS;
            end
            4'(NB_UR + 1): begin
              dc = D_PLUS;
              dr = D_MINUS;
            end
            4'(NB_DL + 1): begin
              dc = D_MINUS;
              dr = D_PLUS;
            end
            4'(NB_DR + 1): begin
              dc = D_PLUS;
              dr = D_PLUS;
            end
            default: begin
              dc = '0;
              dr = '0;
            end
          endcase
        end
      end else if (row_ok) begin
        iss_v    = 1'b1;
        iss_kind = PK_ROW;
        iss_idx  = i_r;
        dr       = 7'd0 - {2'b00, i_r};
      end else if (col_ok) begin
        iss_v    = 1'b1;
        iss_kind = PK_COL;
        iss_idx  = j_r;
        dc       = 7'd0 - {2'b00, j_r};
      end
    end
  end

  assign ncol     = {1'b0, col_r} + dc;
  assign nrow     = {1'b0, row_r} + dr;
  assign oob      = (ncol >= 7'(MAP_DIM)) || (nrow >= 7'(MAP_DIM));
  assign ram_addr = ram_we ? {in_row, in_col} : {nrow[COORD_W-1:0], ncol[COORD_W-1:0]};
  assign val      = pend_oob_r ? '0 : rd_data;
  assign hit      = (val == center_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept_res) state_nxt = ST_RUN;
      ST_RUN:  if (!iss_v) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_v_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= iss_v;
      done_r   <= (state_r == ST_RUN) && !iss_v;
    end
  end

  always_ff @(posedge clk) begin
    pend_kind_r <= iss_kind;
    pend_idx_r  <= iss_idx;
    pend_oob_r  <= oob;
    if (accept_res) begin
      col_r  <= in_col;
      row_r  <= in_row;
      step_r <= '0;
      i_r    <= 5'd1;
      j_r    <= 5'd1;
      rcnt_r <= '0;
      ccnt_r <= '0;
      sx_r   <= in_col;
      sy_r   <= in_row;
    end else begin
      if (iss_v) begin
        case (iss_kind)
          PK_CENTER, PK_NBR: step_r <= step_r + 4'd1;
          PK_ROW:            i_r    <= i_r + 5'd1;
          PK_COL:            j_r    <= j_r + 5'd1;
          default:           step_r <= step_r;
        endcase
      end
      if (pend_v_r) begin
        case (pend_kind_r)
          PK_CENTER: center_r <= val;
          PK_NBR:    eq_r[pend_idx_r[2:0]] <= hit;
          PK_ROW: begin
            if (hit) begin
              rcnt_r <= rcnt_r + 5'd1;
              sy_r   <= row_r - COORD_W'(pend_idx_r);
            end
          end
          PK_COL: begin
            if (hit) begin
              ccnt_r <= ccnt_r + 5'd1;
              sx_r   <= col_r - COORD_W'(pend_idx_r);
            end
          end
          default: center_r <= center_r;
        endcase
      end
    end
  end

  assign busy     = (state_r == ST_RUN);
  assign done     = done_r;
  assign res.eq   = eq_r;
  assign res.rcnt = rcnt_r;
  assign res.ccnt = ccnt_r;
  assign res.sx   = sx_r;
  assign res.sy   = sy_r;
  assign res.col  = col_r;
  assign res.row  = row_r;

  `AQS_ASSERT_SAME(a_write_idle, ram_we, state_r == ST_IDLE, "map write during resolve")
  `AQS_ASSERT_NEXT(a_done_single, done_r, !done_r, "resolve done longer than one cycle")
  `AQS_ASSERT_SAME(a_pend_run, pend_v_r, $past(state_r) == ST_RUN, "read return outside resolve")
  `AQS_ASSERT_NEXT(a_finish, state_r == ST_RUN && !iss_v, done_r && state_r == ST_IDLE,
    "resolve finish without done")

endmodule

`default_nettype wire

FILE: sv/aqs_quarter.sv
// Quarter selection: turns gathered match flags into source pixels, anchor
// index and animation step, registered as one result. Depends on aqs_pkg.
`default_nettype none

module aqs_quarter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              done,
  input  aqs_pkg::seq_res_t res,
  input  aqs_pkg::cfg_t     cfg,
  output logic              out_valid,
  output logic [11:0]       out_anchor_index,
  output logic [15:0]       out_top_left_x,
  output logic [15:0]       out_top_left_y,
  output logic [15:0]       out_top_right_x,
  output logic [15:0]       out_top_right_y,
  output logic [15:0]       out_bottom_left_x,
  output logic [15:0]       out_bottom_left_y,
  output logic [15:0]       out_bottom_right_x,
  output logic [15:0]       out_bottom_right_y,
  output logic [7:0]        out_anim_step_x,
  output logic [6:0]        out_anim_step_y
);
  import aqs_pkg::*;

  logic        l, t, r, b, ls, us, rs, ds, ldiff, rdiff;
  logic [2:0]  qx [4];
  logic [2:0]  qy [4];
  logic [15:0] px [4];
  logic [15:0] py [4];
  logic [15:0] bx, by;
  logic [12:0] anchor;
  logic [7:0]  ax;
  logic [6:0]  ay;

  logic        valid_r;
  logic [11:0] anchor_r;
  logic [15:0] px_r [4];
  logic [15:0] py_r [4];
  logic [7:0]  ax_r;
  logic [6:0]  ay_r;

  assign l  = res.col != '0;
  assign t  = res.row != '0;
  assign r  = ({1'b0, res.col} + 7'd1) < cfg.map_width;
  assign b  = ({1'b0, res.row} + 7'd1) < cfg.map_height;
  assign ls = l && res.eq[NB_L];
  assign us = t && res.eq[NB_U];
  assign rs = r && res.eq[NB_R];
  assign ds = b && res.eq[NB_D];
  assign ldiff = l && !ls;
  assign rdiff = r && !rs;

  assign anchor = 13'(res.sx) + 13'(res.sy) * 13'(cfg.map_width);
  assign bx     = 16'(cfg.origin_x) + 16'(res.ccnt) * 16'(TILE_W);
  assign by     = 16'(cfg.origin_y) + 16'(res.rcnt) * 16'(TILE_H);

  always_comb begin
    if (l && t && !res.eq[NB_UL] && ls && us) begin
      qx[0] = 3'd2; qy[0] = 3'd0;
    end else if (l && t && !ls && !us) begin
      qx[0] = 3'd0; qy[0] = 3'd2;
    end else if (l && !ls) begin
      qx[0] = 3'd0; qy[0] = 3'd4;
    end else if (t && !us) begin
      qx[0] = 3'd2; qy[0] = 3'd2;
    end else begin
      qx[0] = 3'd2; qy[0] = 3'd4;
    end

    if (r && t && !res.eq[NB_UR] && rs && us) begin
      qx[1] = 3'd3; qy[1] = 3'd0;
    end else if (r && t && !rs && !us) begin
      qx[1] = 3'd3; qy[1] = 3'd2;
    end else if (r && !rs) begin
      qx[1] = 3'd3; qy[1] = 3'd4;
    end else if (t && !us) begin
      qx[1] = 3'd1; qy[1] = 3'd2;
    end else begin
      qx[1] = 3'd1; qy[1] = 3'd4;
    end

    if (l && b && !res.eq[NB_DL] && ls && ds) begin
      qx[2] = 3'd2; qy[2] = 3'd1;
    end else if (l && b && !ls && !ds) begin
      qx[2] = 3'd0; qy[2] = 3'd5;
    end else if (l && !ls) begin
      qx[2] = 3'd0; qy[2] = 3'd3;
    end else if (b && !ds) begin
      qx[2] = 3'd2; qy[2] = 3'd5;
    end else begin
      qx[2] = 3'd2; qy[2] = 3'd3;
    end

    if (r && b && !res.eq[NB_DR] && rs && ds) begin
      qx[3] = 3'd3; qy[3] = 3'd1;
    end else if (r && b && !rs && !ds) begin
      qx[3] = 3'd3; qy[3] = 3'd5;
    end else if (r && !rs) begin
      qx[3] = 3'd3; qy[3] = 3'd3;
    end else if (b && !ds) begin
      qx[3] = 3'd1; qy[3] = 3'd5;
    end else begin
      qx[3] = 3'd1; qy[3] = 3'd3;
    end

    if (cfg.tile_mode == MODE_HORIZ) begin
      qx[0] = ldiff ? 3'd0 : 3'd2; qy[0] = 3'd0;
      qx[1] = rdiff ? 3'd3 : 3'd1; qy[1] = 3'd0;
      qx[2] = ldiff ? 3'd0 : 3'd2; qy[2] = 3'd1;
      qx[3] = rdiff ? 3'd3 : 3'd1; qy[3] = 3'd1;
    end
  end

  always_comb begin
    case (cfg.tile_mode)
      MODE_FULL, MODE_HORIZ: begin
        for (int k = 0; k < 4; k++) begin
          px[k] = 16'(cfg.origin_x) + 16'(qx[k]) * 16'(HALF_W);
          py[k] = 16'(cfg.origin_y) + 16'(qy[k]) * 16'(HALF_H);
        end
      end
      default: begin
        px[0] = bx;
        py[0] = by;
        px[1] = bx + 16'(HALF_W);
        py[1] = by;
        px[2] = bx;
        py[2] = by + 16'(HALF_H);
        px[3] = bx + 16'(HALF_W);
        py[3] = by + 16'(HALF_H);
      end
    endcase
  end

  always_comb begin
    ax = '0;
    ay = '0;
    if ($signed(cfg.frame_count) > 8'sd1) begin
      case (cfg.tile_mode)
        MODE_FULL:  ax = 8'(2 * TILE_W);
        MODE_HORIZ: ay = 7'(TILE_H);
        default:    ax = 8'(TILE_W);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      anchor_r <= anchor[11:0];
      px_r     <= px;
      py_r     <= py;
      ax_r     <= ax;
      ay_r     <= ay;
    end
  end

  assign out_valid          = valid_r;
  assign out_anchor_index   = anchor_r;
  assign out_top_left_x     = px_r[0];
  assign out_top_left_y     = py_r[0];
  assign out_top_right_x    = px_r[1];
  assign out_top_right_y    = py_r[1];
  assign out_bottom_left_x  = px_r[2];
  assign out_bottom_left_y  = py_r[2];
  assign out_bottom_right_x = px_r[3];
  assign out_bottom_right_y = py_r[3];
  assign out_anim_step_x    = ax_r;
  assign out_anim_step_y    = ay_r;

endmodule

`default_nettype wire

FILE: sv/autotile_quarter_selector.sv
// Top level of the autotile quarter selector: configuration registers,
// resolve sequencer with map memory, quarter selection. Depends on aqs_pkg, aqs_seq, aqs_quarter.
`default_nettype none

// A write item (in_kind 0) stores a tile value in the 64x64 map memory in the
// transfer cycle and frees the block at once; it gives no result. A resolve
// item (in_kind 1) reads the cell and its neighbours one per cycle over the
// single map memory port: 9 reads in full and horizontal autotile mode,
// 1 + min(count_rows-1, row) + min(count_cols-1, col) reads in single mode;
// no new item is taken until the resolve has finished. busy is high while
// the reads run. The result shows on the out_ ports for exactly one cycle
// with out_valid, in the cycle after busy falls; the receiver cannot hold it
// off. The map is not cleared at reset: a resolve must only touch cells
// written before.
// Write the cfg_ registers only while the block is idle.
module autotile_quarter_selector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_kind,
  input  logic [5:0]                       in_col,
  input  logic [5:0]                       in_row,
  input  logic [15:0]                      in_tile_value,
  output logic                             out_valid,
  output logic [11:0]                      out_anchor_index,
  output logic [15:0]                      out_top_left_x,
  output logic [15:0]                      out_top_left_y,
  output logic [15:0]                      out_top_right_x,
  output logic [15:0]                      out_top_right_y,
  output logic [15:0]                      out_bottom_left_x,
  output logic [15:0]                      out_bottom_left_y,
  output logic [15:0]                      out_bottom_right_x,
  output logic [15:0]                      out_bottom_right_y,
  output logic [7:0]                       out_anim_step_x,
  output logic [6:0]                       out_anim_step_y,
  input  logic                             cfg_we,
  input  logic [aqs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aqs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import aqs_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  seq_res_t res;
  logic     done;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_TILE_MODE:   cfg_nxt.tile_mode   = cfg_wdata[1:0];
        REG_ORIGIN_X:    cfg_nxt.origin_x    = cfg_wdata[14:0];
        REG_ORIGIN_Y:    cfg_nxt.origin_y    = cfg_wdata[14:0];
        REG_COUNT_COLS:  cfg_nxt.count_cols  = cfg_wdata[4:0];
        REG_COUNT_ROWS:  cfg_nxt.count_rows  = cfg_wdata[4:0];
        REG_MAP_WIDTH:   cfg_nxt.map_width   = cfg_wdata[6:0];
        REG_MAP_HEIGHT:  cfg_nxt.map_height  = cfg_wdata[6:0];
        REG_FRAME_COUNT: cfg_nxt.frame_count = cfg_wdata[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tile_mode   <= MODE_SINGLE;
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
      cfg_r.count_cols  <= 5'd1;
      cfg_r.count_rows  <= 5'd1;
      cfg_r.map_width   <= 7'd64;
      cfg_r.map_height  <= 7'd64;
      cfg_r.frame_count <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  aqs_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_kind       (in_kind),
    .in_col        (in_col),
    .in_row        (in_row),
    .in_tile_value (in_tile_value),
    .cfg           (cfg_r),
    .busy          (busy),
    .done          (done),
    .res           (res)
  );

  aqs_quarter u_quarter (
    .clk                (clk),
    .rst_n              (rst_n),
    .done               (done),
    .res                (res),
    .cfg                (cfg_r),
    .out_valid          (out_valid),
    .out_anchor_index   (out_anchor_index),
    .out_top_left_x     (out_top_left_x),
    .out_top_left_y     (out_top_left_y),
    .out_top_right_x    (out_top_right_x),
    .out_top_right_y    (out_top_right_y),
    .out_bottom_left_x  (out_bottom_left_x),
    .out_bottom_left_y  (out_bottom_left_y),
    .out_bottom_right_x (out_bottom_right_x),
    .out_bottom_right_y (out_bottom_right_y),
    .out_anim_step_x    (out_anim_step_x),
    .out_anim_step_y    (out_anim_step_y)
  );

endmodule

`default_nettype wire
